FILE: sv/rms_pkg.sv
// Package for the block RMS level meter: field widths, default block size,
// the controller state type and the accumulator control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rms_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 16;
  // Each square is at most 2^30, so the floor mean square fits in 31 bits.
  localparam int unsigned MEAN_W   = 31;
  // The square root unit works on an even number of bits.
  localparam int unsigned RAD_W    = 32;

  localparam int unsigned DefMaxBlockSamples = 1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIVIDE,
    ST_ROOT
  } rms_state_e;

  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctl_t;

endpackage

`default_nettype wire

FILE: sv/rms_sq_acc.sv
// Bit-serial squarer and block accumulator (sum of squares, sample count).
// Depends on rms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rms_sq_acc #(
  parameter int unsigned SumW = 41,
  parameter int unsigned CntW = 11
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rms_pkg::acc_ctl_t             ctl_i,
  input  wire logic signed [rms_pkg::SAMPLE_W-1:0] sample_i,
  output logic             [SumW-1:0]        sum_o,
  output logic             [CntW-1:0]        cnt_o,
  output logic                               done_o
);
  import rms_pkg::*;

  localparam int unsigned StepW = $clog2(SAMPLE_W);
  localparam int unsigned ProdW = 2 * SAMPLE_W;

  logic [SAMPLE_W-1:0] raw;
  logic [SAMPLE_W-1:0] mag;
  logic [ProdW-1:0]    p_q, p_d;
  logic [SAMPLE_W-1:0] mcand_q;
  logic [SAMPLE_W:0]   part_sum;
  logic [StepW-1:0]    step_q;
  logic                run_q, add_q, done_q;
  logic [SumW-1:0]     sum_q;
  logic [CntW-1:0]     cnt_q;

  assign raw = sample_i;
  assign mag = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;

  // The multiplier bits sit in the low half of the product and leave it
  // one per cycle as the partial sums shift in from the top.
  assign part_sum = {1'b0, p_q[ProdW-1:SAMPLE_W]} +
                    (p_q[0] ? {1'b0, mcand_q} : '0);
  assign p_d      = {part_sum, p_q[SAMPLE_W-1:1]};

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      p_q     <= {{SAMPLE_W{1'b0}}, mag};
      mcand_q <= mag;
    end else if (run_q) begin
      p_q <= p_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      add_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= add_q;
      add_q  <= 1'b0;
      if (ctl_i.start) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(SAMPLE_W - 1)) begin
          run_q <= 1'b0;
          add_q <= 1'b1;
        end
      end
      if (ctl_i.clear) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else if (add_q) begin
        sum_q <= sum_q + SumW'(p_q);
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  assign sum_o  = sum_q;
  assign cnt_o  = cnt_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: sv/rms_div.sv
// Restoring divider, one quotient bit per cycle: sum of squares by count.
// Depends on rms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rms_div #(
  parameter int unsigned SumW = 41,
  parameter int unsigned CntW = 11
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [SumW-1:0]             dividend_i,
  input  wire logic [CntW-1:0]             divisor_i,
  output logic      [rms_pkg::MEAN_W-1:0]  quot_o,
  output logic                             done_o
);
  import rms_pkg::*;

  localparam int unsigned StepW = $clog2(SumW);

  logic [SumW-1:0]  q_q, q_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  div_q;
  logic [CntW:0]    trial, diff;
  logic             ge;
  logic             zero_q;
  logic [StepW-1:0] step_q;
  logic             run_q, done_q;

  assign trial = {rem_q, q_q[SumW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};
  assign rem_d = ge ? diff[CntW-1:0] : trial[CntW-1:0];
  assign q_d   = {q_q[SumW-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q    <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
      zero_q <= (divisor_i == '0);
    end else if (run_q) begin
      q_q   <= q_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(SumW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // An empty block reads as level zero.
  assign quot_o = zero_q ? '0 : q_q[MEAN_W-1:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: sv/rms_sqrt.sv
// Digit-by-digit floor square root, two radicand bits per cycle.
// Depends on rms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rms_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rms_pkg::RAD_W-1:0]   rad_i,
  output logic      [rms_pkg::LEVEL_W-1:0] root_o,
  output logic                             done_o
);
  import rms_pkg::*;

  localparam int unsigned RootW = LEVEL_W;
  localparam int unsigned RemW  = RootW + 2;
  localparam int unsigned Steps = RAD_W / 2;
  localparam int unsigned StepW = $clog2(Steps);

  logic [RAD_W-1:0]  x_q;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [RootW-1:0]  root_q, root_d;
  logic [RemW+1:0]   shifted, trial, diff;
  logic              ge;
  logic [StepW-1:0]  step_q;
  logic              run_q, done_q;

  assign shifted = {rem_q, x_q[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = shifted >= trial;
  assign diff    = shifted - trial;
  assign rem_d   = ge ? diff[RemW-1:0] : shifted[RemW-1:0];
  assign root_d  = {root_q[RootW-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      x_q    <= {x_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(Steps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: sv/block_rms_level_meter.sv
// Block RMS level meter: top level with the sequencing controller.
// Depends on rms_pkg, rms_sq_acc, rms_div and rms_sqrt.
// A counted sample that does not close its block keeps busy high through the bit-serial
// squarer, one accumulate step and one handoff; an ignored sample of a full block that is
// not the last does not make busy rise. A closing sample adds the divider phase (SumW
// quotient bits, SumW = 31 + clog2(MaxBlockSamples), 41 by default) and the square root
// phase; when its block was already full it skips the squarer. Items are taken one
// at a time, and the level strobe comes in the same cycle as busy falls.
// Reset clears the sum, the count and all control; valid_o cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module block_rms_level_meter #(
  parameter int unsigned MaxBlockSamples = rms_pkg::DefMaxBlockSamples
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [rms_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                last_sample_i,
  output logic                                     valid_o,
  output logic             [rms_pkg::LEVEL_W-1:0]  rms_level_o
);
  import rms_pkg::*;

  // Every square is at most 2^30, so the sum needs 31 bits plus the growth
  // from the number of samples; the count must be able to hold the maximum.
  localparam int unsigned SumW = 31 + $clog2(MaxBlockSamples);
  localparam int unsigned CntW = $clog2(MaxBlockSamples + 1);

  rms_state_e state_q, state_d;

  acc_ctl_t            acc_ctl;
  logic [SumW-1:0]     acc_sum;
  logic [CntW-1:0]     acc_cnt;
  logic                acc_done;
  logic                acc_full;
  logic                accept;
  logic                last_q;

  logic                div_start;
  logic [MEAN_W-1:0]   div_quot;
  logic                div_done;

  logic                sqrt_start;
  logic [LEVEL_W-1:0]  sqrt_root;
  logic                sqrt_done;

  logic                valid_q, valid_d;
  logic [LEVEL_W-1:0]  level_q;

  // A transfer happens whenever start is seen while the controller is idle.
  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  // Once the block holds the maximum number of samples, further samples are
  // dropped, though the closing flag of such a sample still ends the block.
  assign acc_full = (acc_cnt == CntW'(MaxBlockSamples));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!acc_full) begin
            state_d = ST_SQUARE;
          end else if (last_sample_i) begin
            state_d = ST_DIVIDE;
          end
        end
      end
      ST_SQUARE: begin
        if (acc_done) begin
          state_d = last_q ? ST_DIVIDE : ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Controller outputs. The divider copies the sum and count at the same edge
  // at which the accumulator clears them, so the accumulator is empty for the next block.
  always_comb begin
    acc_ctl.start = 1'b0;
    div_start     = 1'b0;
    sqrt_start    = 1'b0;
    valid_d       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        acc_ctl.start = accept && !acc_full;
        div_start     = accept && acc_full && last_sample_i;
      end
      ST_SQUARE: begin
        div_start = acc_done && last_q;
      end
      ST_DIVIDE: begin
        sqrt_start = div_done;
      end
      ST_ROOT: begin
        valid_d = sqrt_done;
      end
      default: begin
        acc_ctl.start = 1'b0;
      end
    endcase
    acc_ctl.clear = div_start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // The root of a value below 2^32 always fits the 16-bit level, so the
  // root is stored as it is, with no saturation.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= last_sample_i;
    end
    if (valid_d) begin
      level_q <= sqrt_root;
    end
  end

  rms_sq_acc #(
    .SumW (SumW),
    .CntW (CntW)
  ) u_sq_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (acc_ctl),
    .sample_i (sample_i),
    .sum_o    (acc_sum),
    .cnt_o    (acc_cnt),
    .done_o   (acc_done)
  );

  rms_div #(
    .SumW (SumW),
    .CntW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_sum),
    .divisor_i  (acc_cnt),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  rms_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (RAD_W'(div_quot)),
    .root_o  (sqrt_root),
    .done_o  (sqrt_done)
  );

  assign valid_o     = valid_q;
  assign rms_level_o = level_q;

  // A result only ever follows the end of the square root phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == ST_ROOT))
    else $error("level strobe without a finished square root");

  // The sample count never runs past the block limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_cnt <= CntW'(MaxBlockSamples))
    else $error("sample count exceeds block limit");

  // Closing a block leaves the accumulator empty for the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_ctl.clear |=> (acc_cnt == '0) && (acc_sum == '0))
    else $error("accumulator not cleared at block end");

  // A counted sample always makes the controller busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !acc_full) |=> busy)
    else $error("counted sample did not start the squarer");

endmodule

`default_nettype wire
